/* rtl/core/frs_pkg.sv */
// ----------------------------------------------------------------------------
// Fragment resequencer package
// Shared widths, status and function codes, sequencer states and the request
// and response types of the shared add/subtract unit.
// ----------------------------------------------------------------------------
package frs_pkg;

    localparam int IDX_W = 32;
    localparam int LEN_W = 10;
    localparam int REF_W = 16;
    localparam int CNT_W = 32;

    // Packed stream layouts, first field in the lowest bits.
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 96;

    // Input kind carried on the slave tuser.
    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_FRAG  = 1'b1;

    typedef enum logic [2:0] {
        ST_RELEASED = 3'd0,
        ST_BUFFERED = 3'd1,
        ST_STALE    = 3'd2,
        ST_BEYOND   = 3'd3,
        ST_STARTED  = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIST,
        S_CLASS,
        S_INC,
        S_CHECK,
        S_READ,
        S_EMIT
    } t_state;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef struct packed {
        t_alu_op            op;
        logic [IDX_W-1:0]   a;
        logic [IDX_W-1:0]   b;
    } t_alu_req;

    typedef struct packed {
        logic [IDX_W-1:0]   sum;
        logic               carry;
    } t_alu_res;

endpackage

/* rtl/core/frs_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module frs_ram #(
    parameter int WIDTH = 26,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/frs_alu.sv */
// ----------------------------------------------------------------------------
// Fragment resequencer shared arithmetic unit
// One 32-bit adder/subtractor used by the sequencer for the index distance,
// the byte count and the expected index increment.
// ----------------------------------------------------------------------------
module frs_alu
    import frs_pkg::*;
(
    input  t_alu_req i_req,
    output t_alu_res o_res
);

    logic [IDX_W-1:0] w_b;
    logic             w_cin;
    logic [IDX_W:0]   w_full;

    // Subtraction is a plus the inverted b plus one; carry out means no borrow.
    always_comb begin
        w_b    = (i_req.op == ALU_SUB) ? ~i_req.b : i_req.b;
        w_cin  = (i_req.op == ALU_SUB);
        w_full = {1'b0, i_req.a} + {1'b0, w_b} + {{IDX_W{1'b0}}, w_cin};
    end

    assign o_res.sum   = w_full[IDX_W-1:0];
    assign o_res.carry = w_full[IDX_W];

endmodule

/* rtl/core/fragment_resequencer_unit.sv */
// ----------------------------------------------------------------------------
// Fragment resequencer
// Puts data fragments of one transfer back in index order, buffering those
// that arrive early and releasing each unbroken run as it completes.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one request at a time: tuser selects a start
//   (0) or a data fragment (1). A start clears the expected index, the byte
//   count and every slot, and answers with one result of status started.
//   A fragment answers with one result (buffered, stale or beyond window),
//   or with a run of released results: the fragment itself followed by every
//   buffered successor in order. tlast marks the final result of a request.
//   Steps from acceptance to the load of the output register: a start goes
//   straight to the output step (S_EMIT); a buffered, stale or beyond-window
//   fragment first takes the index distance and the byte count on the shared
//   adder (S_DIST, S_CLASS); an in-order fragment adds the expected index
//   increment (S_INC) before S_CHECK; each buffered successor adds a
//   registered slot RAM read and an index increment (S_READ, S_INC).
//   tready is low from acceptance until the final result is loaded into the
//   output register; a new request may enter while the final result is
//   still held. A stalled master side simply holds the sequencer before
//   its next load.
//   Reset clears the expected index, the byte count and all slot valid bits
//   at once; no clearing pass is needed, the slot RAM is read only where
//   its valid bit is set.
// ----------------------------------------------------------------------------
module fragment_resequencer_unit
    import frs_pkg::*;
#(
    parameter int WINDOW            = 64,
    parameter int MAX_PAYLOAD_BYTES = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Slave side.
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // tdata: frag_index[31:0], frag_length[41:32], payload_ref[57:42], zero fill
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // tuser: func[0]
    input  logic [0:0]            i_s_axis_tuser,
    // Master side.
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // tdata: out_index[31:0], out_length[41:32], out_ref[57:42],
    //        byte_total[89:58], zero fill
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    // tuser: status[2:0]
    output logic [2:0]            o_m_axis_tuser,
    output logic                  o_m_axis_tlast
);

    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int MEM_W  = LEN_W + REF_W;
    localparam logic [CNT_W-1:0]  MaxLen     = CNT_W'(MAX_PAYLOAD_BYTES);
    localparam logic [IDX_W-1:0]  WindowSize = IDX_W'(WINDOW);
    localparam logic [SLOT_W:0]   WindowWide = (SLOT_W+1)'(WINDOW);
    localparam logic [SLOT_W-1:0] LastSlot   = SLOT_W'(WINDOW - 1);

    // Sequencer and transfer state.
    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_expected, n_expected;
    logic [CNT_W-1:0]   r_byte_count, n_byte_count;
    logic [WINDOW-1:0]  r_valid, n_valid;
    logic [SLOT_W-1:0]  r_exp_slot, n_exp_slot;

    // Request under work.
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [LEN_W-1:0]   r_len, n_len;
    logic [REF_W-1:0]   r_ref, n_ref;
    logic               r_stale, n_stale;
    logic               r_far, n_far;
    logic [SLOT_W-1:0]  r_dist_lo, n_dist_lo;

    // Pending result.
    t_status            r_p_status, n_p_status;
    logic [IDX_W-1:0]   r_p_idx, n_p_idx;
    logic [LEN_W-1:0]   r_p_len, n_p_len;
    logic [REF_W-1:0]   r_p_ref, n_p_ref;
    logic [CNT_W-1:0]   r_p_total, n_p_total;

    // Output register.
    logic               r_o_valid, n_o_valid;
    t_status            r_o_status, n_o_status;
    logic [IDX_W-1:0]   r_o_idx, n_o_idx;
    logic [LEN_W-1:0]   r_o_len, n_o_len;
    logic [REF_W-1:0]   r_o_ref, n_o_ref;
    logic [CNT_W-1:0]   r_o_total, n_o_total;
    logic               r_o_last, n_o_last;

    // Shared unit and RAM controls.
    t_alu_req           w_alu_req;
    t_alu_res           w_alu_res;
    logic               w_ram_we;
    logic               w_ram_re;
    logic [MEM_W-1:0]   w_ram_rdata;

    logic               w_accept;
    logic               w_out_free;
    logic               w_next_valid;
    logic               w_hit;
    logic [LEN_W-1:0]   w_len_in;
    logic [LEN_W-1:0]   w_len_sat;
    logic [SLOT_W:0]    w_slot_sum;
    logic [SLOT_W:0]    w_slot_sub;
    logic [SLOT_W-1:0]  w_buf_slot;

    frs_alu u_alu (
        .i_req (w_alu_req),
        .o_res (w_alu_res)
    );

    frs_ram #(
        .WIDTH (MEM_W),
        .DEPTH (WINDOW)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_buf_slot),
        .i_wdata ({r_ref, r_len}),
        .i_re    (w_ram_re),
        .i_raddr (r_exp_slot),
        .o_rdata (w_ram_rdata)
    );

    // Handshake and helper terms.
    always_comb begin
        w_accept     = i_s_axis_tvalid && (r_state == S_IDLE);
        w_out_free   = !r_o_valid || i_m_axis_tready;
        w_next_valid = r_valid[r_exp_slot];
        w_hit        = (r_dist_lo == '0);
        w_len_in     = i_s_axis_tdata[IDX_W +: LEN_W];
        w_len_sat    = (CNT_W'(w_len_in) > MaxLen) ? MaxLen[LEN_W-1:0] : w_len_in;
        // Slot of an early fragment: expected slot plus distance, mod window.
        w_slot_sum   = {1'b0, r_exp_slot} + {1'b0, r_dist_lo};
        w_slot_sub   = w_slot_sum - WindowWide;
        w_buf_slot   = (w_slot_sum >= WindowWide) ? w_slot_sub[SLOT_W-1:0]
                                                  : w_slot_sum[SLOT_W-1:0];
    end

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (i_s_axis_tuser[0] == FUNC_START) ? S_EMIT : S_DIST;
                end
            end
            S_DIST: begin
                n_state = S_CLASS;
            end
            S_CLASS: begin
                if (r_stale || r_far || !w_hit) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_INC;
                end
            end
            S_INC: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (w_out_free) begin
                    n_state = w_next_valid ? S_READ : S_IDLE;
                end
            end
            S_READ: begin
                n_state = S_INC;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Datapath controls and register updates per state.
    always_comb begin
        n_expected   = r_expected;
        n_byte_count = r_byte_count;
        n_valid      = r_valid;
        n_exp_slot   = r_exp_slot;
        n_idx        = r_idx;
        n_len        = r_len;
        n_ref        = r_ref;
        n_stale      = r_stale;
        n_far        = r_far;
        n_dist_lo    = r_dist_lo;
        n_p_status   = r_p_status;
        n_p_idx      = r_p_idx;
        n_p_len      = r_p_len;
        n_p_ref      = r_p_ref;
        n_p_total    = r_p_total;
        n_o_status   = r_o_status;
        n_o_idx      = r_o_idx;
        n_o_len      = r_o_len;
        n_o_ref      = r_o_ref;
        n_o_total    = r_o_total;
        n_o_last     = r_o_last;
        n_o_valid    = r_o_valid && !i_m_axis_tready;
        w_alu_req.op = ALU_ADD;
        w_alu_req.a  = '0;
        w_alu_req.b  = '0;
        w_ram_we     = 1'b0;
        w_ram_re     = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_idx = i_s_axis_tdata[IDX_W-1:0];
                    n_len = w_len_sat;
                    n_ref = i_s_axis_tdata[IDX_W+LEN_W +: REF_W];
                    if (i_s_axis_tuser[0] == FUNC_START) begin
                        n_expected   = '0;
                        n_byte_count = '0;
                        n_valid      = '0;
                        n_exp_slot   = '0;
                        n_p_status   = ST_STARTED;
                        n_p_idx      = '0;
                        n_p_len      = '0;
                        n_p_ref      = '0;
                        n_p_total    = '0;
                    end
                end
            end
            S_DIST: begin
                // Distance ahead of the expected index; a borrow marks stale.
                w_alu_req.op = ALU_SUB;
                w_alu_req.a  = r_idx;
                w_alu_req.b  = r_expected;
                n_stale      = !w_alu_res.carry;
                n_far        = (w_alu_res.sum >= WindowSize);
                n_dist_lo    = w_alu_res.sum[SLOT_W-1:0];
            end
            S_CLASS: begin
                // Classify the fragment; count the bytes of an accepted one and buffer an early one.
                w_alu_req.op = ALU_ADD;
                w_alu_req.a  = r_byte_count;
                w_alu_req.b  = IDX_W'(r_len);
                n_p_idx      = r_idx;
                n_p_len      = r_len;
                n_p_ref      = r_ref;
                n_p_total    = r_byte_count;
                if (r_stale) begin
                    n_p_status = ST_STALE;
                end else if (r_far) begin
                    n_p_status = ST_BEYOND;
                end else begin
                    n_byte_count = w_alu_res.sum;
                    n_p_total    = w_alu_res.sum;
                    if (w_hit) begin
                        n_p_status = ST_RELEASED;
                    end else begin
                        n_p_status          = ST_BUFFERED;
                        w_ram_we            = 1'b1;
                        n_valid[w_buf_slot] = 1'b1;
                    end
                end
            end
            S_INC: begin
                // Advance the expected index and its slot; index wrap restarts at slot 0.
                w_alu_req.op = ALU_ADD;
                w_alu_req.a  = r_expected;
                w_alu_req.b  = IDX_W'(1);
                n_expected   = w_alu_res.sum;
                if (w_alu_res.carry || (r_exp_slot == LastSlot)) begin
                    n_exp_slot = '0;
                end else begin
                    n_exp_slot = r_exp_slot + SLOT_W'(1);
                end
            end
            S_CHECK: begin
                // Hand the pending release over; fetch the successor if buffered.
                if (w_out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_p_status;
                    n_o_idx    = r_p_idx;
                    n_o_len    = r_p_len;
                    n_o_ref    = r_p_ref;
                    n_o_total  = r_p_total;
                    n_o_last   = !w_next_valid;
                    if (w_next_valid) begin
                        w_ram_re            = 1'b1;
                        n_valid[r_exp_slot] = 1'b0;
                        n_p_idx             = r_expected;
                    end
                end
            end
            S_READ: begin
                n_p_status = ST_RELEASED;
                n_p_len    = w_ram_rdata[LEN_W-1:0];
                n_p_ref    = w_ram_rdata[LEN_W +: REF_W];
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_p_status;
                    n_o_idx    = r_p_idx;
                    n_o_len    = r_p_len;
                    n_o_ref    = r_p_ref;
                    n_o_total  = r_p_total;
                    n_o_last   = 1'b1;
                end
            end
            default: begin
                n_o_valid = r_o_valid && !i_m_axis_tready;
            end
        endcase
    end

    // Control registers with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_expected   <= '0;
            r_byte_count <= '0;
            r_valid      <= '0;
            r_exp_slot   <= '0;
            r_o_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_expected   <= n_expected;
            r_byte_count <= n_byte_count;
            r_valid      <= n_valid;
            r_exp_slot   <= n_exp_slot;
            r_o_valid    <= n_o_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_len      <= n_len;
        r_ref      <= n_ref;
        r_stale    <= n_stale;
        r_far      <= n_far;
        r_dist_lo  <= n_dist_lo;
        r_p_status <= n_p_status;
        r_p_idx    <= n_p_idx;
        r_p_len    <= n_p_len;
        r_p_ref    <= n_p_ref;
        r_p_total  <= n_p_total;
        r_o_status <= n_o_status;
        r_o_idx    <= n_o_idx;
        r_o_len    <= n_o_len;
        r_o_ref    <= n_o_ref;
        r_o_total  <= n_o_total;
        r_o_last   <= n_o_last;
    end

    // Port drive.
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = {{(OUT_DATA_W-IDX_W-LEN_W-REF_W-CNT_W){1'b0}},
                              r_o_total, r_o_ref, r_o_len, r_o_idx};
    assign o_m_axis_tuser  = r_o_status;
    assign o_m_axis_tlast  = r_o_last;

endmodule

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// Fragment resequencer testbench
// Drives start and fragment requests into the slave stream and checks every
// result on the master stream against an in-bench tracker of the expected
// index, the byte count and the slot contents. Directed cases come first,
// then a full window release, then random windowed bursts mixed with stale,
// far-ahead and start requests, under random idling on both streams.
// ----------------------------------------------------------------------------
module testbench
    import frs_pkg::*;
;

    localparam int WINDOW_SLOTS = 64;
    localparam int MAX_LEN      = 1023;
    localparam int MAX_DESC     = 65535;

    typedef struct packed {
        t_status            status;
        logic [IDX_W-1:0]   index;
        logic [LEN_W-1:0]   length;
        logic [REF_W-1:0]   desc;
        logic [CNT_W-1:0]   total;
        logic               last;
    } t_frag_result;

    logic                  i_clk;
    logic                  rst_n;
    logic                  s_valid;
    logic                  s_ready;
    logic [IN_DATA_W-1:0]  s_data;
    logic [0:0]            s_user;
    logic                  m_valid;
    logic                  m_ready;
    logic [OUT_DATA_W-1:0] m_data;
    logic [2:0]            m_user;
    logic                  m_last;

    // Tracker state for the transfer in progress.
    logic [IDX_W-1:0]      next_index;
    logic [CNT_W-1:0]      byte_sum;
    logic                  slot_full [WINDOW_SLOTS];
    logic [LEN_W-1:0]      slot_len  [WINDOW_SLOTS];
    logic [REF_W-1:0]      slot_desc [WINDOW_SLOTS];

    t_frag_result          due_results [$];
    int unsigned           mismatch_count;
    // Idling odds out of 8 per opportunity on either stream; 0 means none.
    int unsigned           gap_odds;

    fragment_resequencer_unit #(
        .WINDOW (WINDOW_SLOTS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .o_m_axis_tlast  (m_last)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard limit on the run time.
    initial begin
        #10_000_000;
        $display("fragment_resequencer_unit verification failed");
        $finish;
    end

    // One printed line per mismatch, counted for the final verdict.
    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    function automatic t_frag_result make_result(input t_status st,
            input logic [IDX_W-1:0] idx, input logic [LEN_W-1:0] len,
            input logic [REF_W-1:0] desc, input logic [CNT_W-1:0] total,
            input logic lst);
        t_frag_result r;
        r.status = st;
        r.index  = idx;
        r.length = len;
        r.desc   = desc;
        r.total  = total;
        r.last   = lst;
        return r;
    endfunction

    // Works out the results of one accepted request and queues them.
    function automatic void predict_resequence(input logic func,
            input logic [IDX_W-1:0] idx, input logic [LEN_W-1:0] len,
            input logic [REF_W-1:0] desc);
        logic [IDX_W-1:0] gap;
        int unsigned      s;
        t_frag_result     run [$];
        if (func == FUNC_START) begin
            next_index = '0;
            byte_sum   = '0;
            foreach (slot_full[k]) slot_full[k] = 1'b0;
            due_results.push_back(make_result(ST_STARTED, '0, '0, '0, '0, 1'b1));
            return;
        end
        if (idx < next_index) begin
            due_results.push_back(make_result(ST_STALE, idx, len, desc, byte_sum, 1'b1));
            return;
        end
        gap = idx - next_index;
        if (gap >= WINDOW_SLOTS) begin
            due_results.push_back(make_result(ST_BEYOND, idx, len, desc, byte_sum, 1'b1));
            return;
        end
        byte_sum = byte_sum + len;
        if (gap != 0) begin
            s = idx % WINDOW_SLOTS;
            slot_full[s] = 1'b1;
            slot_len[s]  = len;
            slot_desc[s] = desc;
            due_results.push_back(make_result(ST_BUFFERED, idx, len, desc, byte_sum, 1'b1));
            return;
        end
        // In-order fragment: release it and every buffered successor.
        run.push_back(make_result(ST_RELEASED, idx, len, desc, byte_sum, 1'b0));
        next_index = next_index + 1;
        s = next_index % WINDOW_SLOTS;
        while (run.size() < WINDOW_SLOTS && slot_full[s]) begin
            run.push_back(make_result(ST_RELEASED, next_index, slot_len[s], slot_desc[s],
                                      byte_sum, 1'b0));
            slot_full[s] = 1'b0;
            next_index = next_index + 1;
            s = next_index % WINDOW_SLOTS;
        end
        run[run.size()-1].last = 1'b1;
        foreach (run[k]) due_results.push_back(run[k]);
    endfunction

    // Sends one request, with an optional idle burst first, and records it.
    task automatic send_request(input logic func, input logic [IDX_W-1:0] idx,
            input logic [LEN_W-1:0] len, input logic [REF_W-1:0] desc);
        int unsigned pause;
        if (gap_odds != 0 && $urandom_range(1, 8) <= gap_odds) begin
            pause = $urandom_range(1, 5);
            s_valid <= 1'b0;
            repeat (pause) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_user  <= func;
        s_data  <= {6'd0, desc, len, idx};
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        predict_resequence(func, idx, len, desc);
    endtask

    task automatic send_fragment(input logic [IDX_W-1:0] idx);
        send_request(FUNC_FRAG, idx, LEN_W'($urandom_range(0, MAX_LEN)),
                     REF_W'($urandom_range(0, MAX_DESC)));
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (32) @(posedge i_clk);
    endtask

    // Master side pacing: random stall bursts unless idling is switched off.
    initial begin : sink_pacing
        int unsigned hold;
        m_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (gap_odds != 0 && $urandom_range(1, 8) <= gap_odds) begin
                hold = $urandom_range(1, 5);
                m_ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            m_ready <= 1'b1;
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge i_clk) begin : result_check
        t_frag_result want;
        if (rst_n && m_valid && m_ready) begin
            if (due_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result status %0d index %0h",
                                          m_user, m_data[31:0]));
            end else begin
                want = due_results.pop_front();
                if (m_user !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d", m_user,
                                              want.status));
                if (m_data[31:0] !== want.index)
                    report_mismatch($sformatf("index got %0h want %0h", m_data[31:0],
                                              want.index));
                if (m_data[41:32] !== want.length)
                    report_mismatch($sformatf("length got %0d want %0d", m_data[41:32],
                                              want.length));
                if (m_data[57:42] !== want.desc)
                    report_mismatch($sformatf("descriptor got %0h want %0h",
                                              m_data[57:42], want.desc));
                if (m_data[89:58] !== want.total)
                    report_mismatch($sformatf("byte total got %0h want %0h",
                                              m_data[89:58], want.total));
                if (m_last !== want.last)
                    report_mismatch($sformatf("tlast got %0b want %0b index %0h", m_last,
                                              want.last, want.index));
            end
        end
    end

    // Field extremes, every status and the slot clearing of a start.
    task automatic test_directed_cases();
        gap_odds = 2;
        send_request(FUNC_START, '1, '1, '1);
        send_request(FUNC_FRAG, 32'd0, 10'd1023, 16'hFFFF);
        send_request(FUNC_FRAG, 32'd2, 10'd0, 16'h0000);
        send_request(FUNC_FRAG, 32'd3, 10'd5, 16'h1234);
        // A repeat overwrites the slot and is counted again.
        send_request(FUNC_FRAG, 32'd3, 10'd7, 16'hABCD);
        // Releases 1, 2 and 3 in one run.
        send_request(FUNC_FRAG, 32'd1, 10'd512, 16'h5A5A);
        send_request(FUNC_FRAG, 32'd0, 10'd9, 16'h0001);
        send_request(FUNC_FRAG, 32'd3, 10'd1, 16'h8000);
        // Last index inside the window, then the first one past it.
        send_request(FUNC_FRAG, 32'd67, 10'd100, 16'h00FF);
        send_request(FUNC_FRAG, 32'd68, 10'd200, 16'hFF00);
        send_request(FUNC_FRAG, 32'hFFFF_FFFF, 10'd1023, 16'hFFFF);
        send_request(FUNC_FRAG, 32'hAAAA_5555, 10'h2AA, 16'h5555);
        // After a start the slot that held index 67 must read as empty.
        send_request(FUNC_START, 32'h5555_AAAA, 10'h155, 16'hAAAA);
        send_request(FUNC_FRAG, 32'd0, 10'd3, 16'h0003);
        send_request(FUNC_FRAG, 32'd1, 10'd4, 16'h0004);
        send_request(FUNC_FRAG, 32'd2, 10'd5, 16'h0005);
        send_request(FUNC_FRAG, 32'd66, 10'd6, 16'h0006);
        send_request(FUNC_FRAG, 32'd3, 10'd7, 16'h0007);
        drain_results();
    endtask

    // Fill the whole window backwards, then release all of it in one run.
    task automatic test_full_window();
        gap_odds = 3;
        send_request(FUNC_START, '0, '0, '0);
        for (int k = WINDOW_SLOTS - 1; k >= 0; k--)
            send_fragment(k);
        send_fragment(WINDOW_SLOTS);
        drain_results();
    endtask

    // Mostly shuffled windowed bursts with holes and repeats, plus noise.
    task automatic test_random_traffic(input int unsigned total);
        int unsigned      sent;
        int unsigned      pick;
        int unsigned      span;
        int unsigned      j;
        int unsigned      tmp;
        int unsigned      order [WINDOW_SLOTS];
        logic [IDX_W-1:0] base;
        sent = 0;
        while (sent < total) begin
            if (sent + 40 >= total)
                gap_odds = 0;
            else
                gap_odds = $urandom_range(0, 4);
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                send_request(FUNC_START, $urandom(), LEN_W'($urandom_range(0, MAX_LEN)),
                             REF_W'($urandom_range(0, MAX_DESC)));
                sent++;
            end else if (pick < 80) begin
                if ($urandom_range(0, 9) == 0)
                    span = $urandom_range(17, WINDOW_SLOTS);
                else
                    span = $urandom_range(1, 16);
                base = next_index;
                for (int k = 0; k < span; k++) order[k] = k;
                for (int k = span - 1; k > 0; k--) begin
                    j = $urandom_range(0, k);
                    tmp = order[k];
                    order[k] = order[j];
                    order[j] = tmp;
                end
                for (int k = 0; k < span; k++) begin
                    // Occasionally leave a hole or send a repeat.
                    if ($urandom_range(0, 19) != 0) begin
                        send_fragment(base + order[k]);
                        sent++;
                    end
                    if ($urandom_range(0, 14) == 0) begin
                        send_fragment(base + order[k]);
                        sent++;
                    end
                end
            end else if (pick < 88 && next_index != 0) begin
                send_fragment($urandom_range(0, next_index - 1));
                sent++;
            end else if (pick < 94) begin
                send_fragment(next_index + WINDOW_SLOTS + $urandom_range(0, 3));
                sent++;
            end else begin
                send_fragment($urandom());
                sent++;
            end
        end
        drain_results();
    endtask

    // Test sequence.
    initial begin
        rst_n          = 1'b0;
        s_valid        = 1'b0;
        s_data         = '0;
        s_user         = FUNC_START;
        gap_odds       = 0;
        mismatch_count = 0;
        next_index     = '0;
        byte_sum       = '0;
        foreach (slot_full[k]) slot_full[k] = 1'b0;
        repeat (9) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_full_window();
        test_random_traffic(220);
        if (mismatch_count == 0) begin
            $display("fragment_resequencer_unit verification clean");
        end else begin
            $display("fragment_resequencer_unit verification failed");
        end
        $finish;
    end

endmodule
